// ----- hdl/slip_frame_codec_defines.svh -----
// ---------------------------------------------------------------------------
// SLIP frame codec assertion macros
// Shared property wrappers; clock clk_i and reset rst_ni are assumed in scope.
// ---------------------------------------------------------------------------
`ifndef SLIP_FRAME_CODEC_DEFINES_SVH
`define SLIP_FRAME_CODEC_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sfc_pkg.sv -----
// ---------------------------------------------------------------------------
// sfc_pkg
// Codes, action encoding and the job record passed from front to back end.
// ---------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

  // SLIP special characters
  localparam logic [7:0] CHAR_END     = 8'hC0;
  localparam logic [7:0] CHAR_ESC     = 8'hDB;
  localparam logic [7:0] CHAR_ESC_END = 8'hDC;
  localparam logic [7:0] CHAR_ESC_ESC = 8'hDD;

  // Per-item action
  typedef enum logic [1:0] {
    ACT_RX    = 2'd0,
    ACT_TX    = 2'd1,
    ACT_EMPTY = 2'd2,
    ACT_RSVD  = 2'd3
  } sfc_action_e;

  // One classified item: 1 to 4 result bytes
  typedef struct packed {
    logic            dir;       // 0 receive, 1 transmit
    logic            fend;      // receive frame end
    logic [1:0]      last_idx;  // index of final byte
    logic [3:0][7:0] bytes;
  } sfc_job_t;

  // FIFO status toward the front end and back end
  typedef struct packed {
    logic full;
    logic valid;
  } sfc_fifo_st_t;

endpackage

`default_nettype wire

// ----- hdl/sfc_front.sv -----
// ---------------------------------------------------------------------------
// sfc_front
// Accepts items, tracks escape and packet state, and builds a job for each item that yields result bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module sfc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  sfc_pkg::sfc_fifo_st_t fifo_st_i,
  output logic               push_o,
  output sfc_pkg::sfc_job_t  job_o
);
  import sfc_pkg::*;

  logic        esc_q, esc_d;
  logic        inpkt_q, inpkt_d;
  logic        accept;
  logic        has_res;
  sfc_job_t    job;
  sfc_action_e act;

  assign in_stall_o = fifo_st_i.full;
  assign accept     = in_valid_i && !fifo_st_i.full;
  assign act        = sfc_action_e'(action_i);

  // Classify the item and lay out its result bytes
  always_comb begin
    logic [2:0] n;
    n        = '0;
    esc_d    = esc_q;
    inpkt_d  = inpkt_q;
    has_res  = 1'b0;
    job      = '0;
    unique case (act)
      ACT_RX: begin
        job.dir = 1'b0;
        if (esc_q) begin
          esc_d = 1'b0;
          if (data_byte_i == CHAR_ESC_END) begin
            job.bytes[0] = CHAR_END;
            has_res      = 1'b1;
          end else if (data_byte_i == CHAR_ESC_ESC) begin
            job.bytes[0] = CHAR_ESC;
            has_res      = 1'b1;
          end
        end else if (data_byte_i == CHAR_END) begin
          job.fend = 1'b1;
          has_res  = 1'b1;
        end else if (data_byte_i == CHAR_ESC) begin
          esc_d = 1'b1;
        end else begin
          job.bytes[0] = data_byte_i;
          has_res      = 1'b1;
        end
      end
      ACT_TX: begin
        job.dir = 1'b1;
        has_res = 1'b1;
        // opening END for a new packet
        if (!inpkt_q) begin
          job.bytes[0] = CHAR_END;
          n            = 3'd1;
        end
        inpkt_d = 1'b1;
        if (data_byte_i == CHAR_END) begin
          job.bytes[n[1:0]]        = CHAR_ESC;
          job.bytes[2'(n + 3'd1)]  = CHAR_ESC_END;
          n                        = n + 3'd2;
        end else if (data_byte_i == CHAR_ESC) begin
          job.bytes[n[1:0]]        = CHAR_ESC;
          job.bytes[2'(n + 3'd1)]  = CHAR_ESC_ESC;
          n                        = n + 3'd2;
        end else begin
          job.bytes[n[1:0]] = data_byte_i;
          n                 = n + 3'd1;
        end
        // closing END
        if (last_byte_i) begin
          job.bytes[n[1:0]] = CHAR_END;
          n                 = n + 3'd1;
          inpkt_d           = 1'b0;
        end
        job.last_idx = 2'(n - 3'd1);
      end
      ACT_EMPTY: begin
        job.dir      = 1'b1;
        job.bytes[0] = CHAR_END;
        job.bytes[1] = CHAR_END;
        job.last_idx = 2'd1;
        has_res      = 1'b1;
        inpkt_d      = 1'b0;
      end
      ACT_RSVD: begin
        has_res = 1'b0;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  assign push_o = accept && has_res;
  assign job_o  = job;

  // Codec state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b0;
      inpkt_q <= 1'b0;
    end else if (accept) begin
      esc_q   <= esc_d;
      inpkt_q <= inpkt_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sfc_fifo.sv -----
// ---------------------------------------------------------------------------
// sfc_fifo
// Small register queue of jobs between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module sfc_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sfc_pkg::sfc_job_t     job_i,
  input  logic                  pop_i,
  output sfc_pkg::sfc_job_t     job_o,
  output sfc_pkg::sfc_fifo_st_t st_o
);
  import sfc_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sfc_job_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign st_o.full  = (cnt_q == CW'(DEPTH));
  assign st_o.valid = (cnt_q != '0);
  assign do_push    = push_i && !st_o.full;
  assign do_pop     = pop_i && st_o.valid;
  assign job_o      = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sfc_back.sv -----
// ---------------------------------------------------------------------------
// sfc_back
// Walks each job's bytes into the output register, one beat per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module sfc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sfc_pkg::sfc_fifo_st_t fifo_st_i,
  input  sfc_pkg::sfc_job_t     job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  direction_o,
  output logic [7:0]            out_byte_o,
  output logic                  frame_end_o,
  output logic                  run_last_o
);
  import sfc_pkg::*;

  sfc_job_t   job_q;
  logic       job_vld_q;
  logic [1:0] idx_q;
  logic       out_vld_q, out_dir_q, out_fend_q, out_last_q;
  logic [7:0] out_byte_q;
  logic       load_ok, adv, last_beat;

  // Output register frees when empty or taken this cycle
  assign load_ok   = !out_vld_q || !out_stall_i;
  assign adv       = job_vld_q && load_ok;
  assign last_beat = (idx_q == job_q.last_idx);
  assign pop_o     = fifo_st_i.valid && (!job_vld_q || (adv && last_beat));

  // Job sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (pop_o) begin
      job_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (adv) begin
      job_vld_q <= !last_beat;
      idx_q     <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  // Output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_ok) begin
      out_vld_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_dir_q  <= job_q.dir;
      out_byte_q <= job_q.bytes[idx_q];
      out_fend_q <= job_q.fend;
      out_last_q <= last_beat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign direction_o = out_dir_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = out_fend_q;
  assign run_last_o  = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/slip_frame_codec.sv -----
// ---------------------------------------------------------------------------
// slip_frame_codec
// SLIP framing codec: receive decode and transmit encode in one block.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------
//   in      | input     | in_valid_i/in_stall_o | action_i, data_byte_i, last_byte_i
//   out     | output    | out_valid_o/out_stall_i | direction_o, out_byte_o,
//           |           |                       | frame_end_o, run_last_o
//
// An item is taken whenever the job queue has room; the back end then
// drives one output beat per cycle while out_stall_i is low, so an item
// with k result beats (1 to 4) holds the shared output register for k beats.
// The first beat passes through the job queue, the job register and the output register.
// Reset clears the escape and packet state, the queue and the output valid.
// Output stalls back up through the queue to in_stall_o.
// ---------------------------------------------------------------------------
`default_nettype none

`include "slip_frame_codec_defines.svh"

module slip_frame_codec #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       direction_o,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o,
  output logic       run_last_o
);
  import sfc_pkg::*;

  logic         push, pop;
  sfc_job_t     job_in, job_out;
  sfc_fifo_st_t fifo_st;

  // Front end: accept and classify
  sfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .fifo_st_i   (fifo_st),
    .push_o      (push),
    .job_o       (job_in)
  );

  // Job queue
  sfc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .st_o   (fifo_st)
  );

  // Back end: emit beats
  sfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_st_i   (fifo_st),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .direction_o (direction_o),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o),
    .run_last_o  (run_last_o)
  );

  // Checks
  `SFC_ASSERT_NOW(a_no_overflow, push, !fifo_st.full, "job pushed into full queue")
  `SFC_ASSERT_NOW(a_fend_shape, out_valid_o && frame_end_o, !direction_o && out_byte_o == 8'h00, "frame end beat malformed")
  `SFC_ASSERT_NOW(a_rx_single, out_valid_o && !direction_o, run_last_o, "receive item gave more than one beat")
  `SFC_ASSERT_NEXT(a_run_cont, out_valid_o && !out_stall_i && !run_last_o, out_valid_o, "gap inside a multi-beat run")

endmodule

`default_nettype wire
